/* rtl/core/ordered_list_insert_delete_macros.svh */
// Assertion macros for the ordered list block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Next-cycle implication, checked outside reset.
`define OLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

/* rtl/core/olid_pkg.sv */
// Shared types and codes for the ordered list block.
// No dependencies; used by olid_rsp_reg and ordered_list_insert_delete.
package olid_pkg;

  // Request operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_DUMP   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_POS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL        = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND   = 2'd3;

  // Request word
  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  // Result word
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
    logic [4:0]         count;
  } rsp_t;

endpackage

/* rtl/core/olid_rsp_reg.sv */
// Output register for result words: holds one word until the sink takes it.
// Depends on olid_pkg for the result word type.
module olid_rsp_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  olid_pkg::rsp_t load_data,
  output logic          free,
  output logic          valid,
  input  logic          ready,
  output olid_pkg::rsp_t data
);
  import olid_pkg::*;

  // slot can take a new word if empty or being drained this cycle
  assign free = !valid || ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

/* rtl/core/ordered_list_insert_delete.sv */
// Ordered list: positional insert, first-match delete, clear and dump over one RAM.
// Insert moves entries from the position up by one, then writes the value; delete scans
// from the head, moving later entries down one. Clear, rejected requests and an empty-list
// delete go to a status word. The RAM shifts one entry a cycle; each dump word is read,
// then loaded. Requests are taken in idle, after the last word loads; sink stalls delay them.
// Reset (rst, synchronous) empties the list; RAM contents are not cleared.
module ordered_list_insert_delete #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  olid_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output olid_pkg::rsp_t rsp
);
  import olid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_DEL  = 5'b00100,
    ST_DUMP = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic                  pend, pend_next;
  logic                  found, found_next;
  logic [1:0]            res_status, res_status_next;
  logic [DATA_WIDTH-1:0] op_val, op_val_next;
  logic [CNT_W-1:0]      op_pos, op_pos_next;
  logic [AW-1:0]         pidx, pidx_next;

  // entry RAM
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  re, we;
  logic [AW-1:0]         ra, wa;
  logic [DATA_WIDTH-1:0] wd;

  // output register hookup
  logic slot_free;
  logic ld;
  rsp_t ld_data;

  // width adapters
  logic [DATA_WIDTH+31:0] val_wide;
  logic [DATA_WIDTH-1:0]  val_keep;
  logic [DATA_WIDTH+31:0] elem_wide;
  logic [CNT_W+4:0]       cnt_wide;
  logic [4:0]             cnt_out;
  logic [CMP_W-1:0]       pos_ext, cnt_ext;
  logic [CNT_W-1:0]       idx_dec;
  logic                   full;
  logic                   dump_last;

  assign val_wide  = {{DATA_WIDTH{1'b0}}, req.value};
  assign val_keep  = val_wide[DATA_WIDTH-1:0];
  assign elem_wide = {32'b0, rd_data};
  assign cnt_wide  = {5'b0, cnt};
  assign cnt_out   = cnt_wide[4:0];
  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(cnt);
  assign idx_dec   = idx - CNT_W'(1);
  assign full      = (cnt == CNT_W'(CAPACITY));
  assign dump_last = ((CNT_W'(pidx) + CNT_W'(1)) == cnt);

  assign req_ready = (state == ST_IDLE);

  // sequencer: next state, RAM controls, result load
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    idx_next        = idx;
    pend_next       = pend;
    found_next      = found;
    res_status_next = res_status;
    op_val_next     = op_val;
    op_pos_next     = op_pos;
    pidx_next       = pidx;
    re              = 1'b0;
    ra              = '0;
    we              = 1'b0;
    wa              = '0;
    wd              = rd_data;
    ld              = 1'b0;
    ld_data         = '0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.mode)
            MODE_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res_status_next = STATUS_POS_INVALID;
                state_next      = ST_RESP;
              end else if (full) begin
                res_status_next = STATUS_FULL;
                state_next      = ST_RESP;
              end else begin
                op_pos_next = CNT_W'(req.position);
                op_val_next = val_keep;
                idx_next    = cnt;
                state_next  = ST_INS;
              end
            end
            MODE_DELETE: begin
              op_val_next = val_keep;
              idx_next    = '0;
              found_next  = 1'b0;
              if (cnt == '0) begin
                res_status_next = STATUS_NOT_FOUND;
                state_next      = ST_RESP;
              end else begin
                state_next = ST_DEL;
              end
            end
            MODE_CLEAR: begin
              cnt_next        = '0;
              res_status_next = STATUS_OK;
              state_next      = ST_RESP;
            end
            MODE_DUMP: begin
              idx_next = '0;
              if (cnt == '0) begin
                res_status_next = STATUS_OK;
                state_next      = ST_RESP;
              end else begin
                state_next = ST_DUMP;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      // shift tail back by one, top down, then drop the new value in
      ST_INS: begin
        if (pend) begin
          we        = 1'b1;
          wa        = pidx;
          wd        = rd_data;
          pend_next = 1'b0;
        end
        if (idx > op_pos) begin
          re        = 1'b1;
          ra        = idx_dec[AW-1:0];
          pend_next = 1'b1;
          pidx_next = idx[AW-1:0];
          idx_next  = idx_dec;
        end else if (!pend) begin
          we              = 1'b1;
          wa              = op_pos[AW-1:0];
          wd              = op_val;
          cnt_next        = cnt + CNT_W'(1);
          res_status_next = STATUS_OK;
          state_next      = ST_RESP;
        end
      end

      // one pass: find first match, move every later entry down one
      ST_DEL: begin
        if (pend) begin
          if (found) begin
            we = 1'b1;
            wa = pidx - AW'(1);
            wd = rd_data;
          end else if (rd_data == op_val) begin
            found_next = 1'b1;
          end
          pend_next = 1'b0;
        end
        if (idx < cnt) begin
          re        = 1'b1;
          ra        = idx[AW-1:0];
          pend_next = 1'b1;
          pidx_next = idx[AW-1:0];
          idx_next  = idx + CNT_W'(1);
        end else if (!pend) begin
          if (found) begin
            cnt_next        = cnt - CNT_W'(1);
            res_status_next = STATUS_OK;
          end else begin
            res_status_next = STATUS_NOT_FOUND;
          end
          state_next = ST_RESP;
        end
      end

      // read one entry only when the output slot is sure to be free next cycle
      ST_DUMP: begin
        if (pend) begin
          ld                    = 1'b1;
          ld_data.status        = STATUS_OK;
          ld_data.element       = elem_wide[31:0];
          ld_data.element_valid = 1'b1;
          ld_data.last          = dump_last;
          ld_data.count         = cnt_out;
          pend_next             = 1'b0;
        end else if (idx < cnt) begin
          if (slot_free) begin
            re        = 1'b1;
            ra        = idx[AW-1:0];
            pend_next = 1'b1;
            pidx_next = idx[AW-1:0];
            idx_next  = idx + CNT_W'(1);
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      // single status word
      ST_RESP: begin
        if (slot_free) begin
          ld                    = 1'b1;
          ld_data.status        = res_status;
          ld_data.element       = '0;
          ld_data.element_valid = 1'b0;
          ld_data.last          = 1'b1;
          ld_data.count         = cnt_out;
          state_next            = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      idx        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      res_status <= STATUS_OK;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      idx        <= idx_next;
      pend       <= pend_next;
      found      <= found_next;
      res_status <= res_status_next;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    op_val <= op_val_next;
    op_pos <= op_pos_next;
    pidx   <= pidx_next;
  end

  // entry RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  olid_rsp_reg u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (ld),
    .load_data (ld_data),
    .free      (slot_free),
    .valid     (rsp_valid),
    .ready     (rsp_ready),
    .data      (rsp)
  );

  // checks
  `include "ordered_list_insert_delete_macros.svh"

  `OLID_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CNT_W'(CAPACITY))
  `OLID_ASSERT_NOW(a_dump_slot, (state == ST_DUMP) && pend, slot_free)
  `OLID_ASSERT_NOW(a_ram_addr, we && re, wa != ra)
  `OLID_ASSERT_NEXT(a_ins_cnt, (state == ST_INS) && (idx == op_pos) && !pend,
                    cnt == ($past(cnt) + CNT_W'(1)))

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for ordered_list_insert_delete: positional insert,
// first-match delete, clear and dump. Needs olid_pkg and the block RTL only;
// a shadow copy of the list predicts every result word.
module tb_top;
  import olid_pkg::*;

  localparam int LIST_CAP = 16;

  // Shadow list: predicts result words and checks what the block returns
  class list_shadow;
    logic [31:0] slots [LIST_CAP];
    int unsigned fill;
    rsp_t        pending_words [$];
    int unsigned errors;
    int unsigned words_checked;
    int unsigned requests;
    int unsigned dumps;
    int unsigned full_hits;
    int unsigned miss_hits;
    int unsigned bad_pos_hits;

    function void push_word(logic [1:0] st, logic [31:0] el, logic ev, logic lst);
      rsp_t w;
      w.status        = st;
      w.element       = el;
      w.element_valid = ev;
      w.last          = lst;
      w.count         = fill[4:0];
      pending_words.push_back(w);
    endfunction

    // Apply one accepted request to the shadow list
    function void apply_request(req_t r);
      int i;
      int hit;
      requests++;
      case (r.mode)
        MODE_INSERT: begin
          if (r.position > fill) begin
            bad_pos_hits++;
            push_word(STATUS_POS_INVALID, '0, 1'b0, 1'b1);
          end else if (fill >= LIST_CAP) begin
            full_hits++;
            push_word(STATUS_FULL, '0, 1'b0, 1'b1);
          end else begin
            for (i = fill; i > r.position; i--) slots[i] = slots[i-1];
            slots[r.position] = r.value;
            fill++;
            push_word(STATUS_OK, '0, 1'b0, 1'b1);
          end
        end
        MODE_DELETE: begin
          hit = -1;
          for (i = 0; i < fill; i++) begin
            if (hit < 0 && slots[i] == r.value) hit = i;
          end
          if (hit < 0) begin
            miss_hits++;
            push_word(STATUS_NOT_FOUND, '0, 1'b0, 1'b1);
          end else begin
            for (i = hit; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            push_word(STATUS_OK, '0, 1'b0, 1'b1);
          end
        end
        MODE_CLEAR: begin
          fill = 0;
          push_word(STATUS_OK, '0, 1'b0, 1'b1);
        end
        default: begin
          dumps++;
          if (fill == 0) push_word(STATUS_OK, '0, 1'b0, 1'b1);
          for (i = 0; i < fill; i++) push_word(STATUS_OK, slots[i], 1'b1, i + 1 == fill);
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_word(rsp_t got);
      rsp_t exp;
      if (pending_words.size() == 0) begin
        $error("result word with none expected: %p", got);
        errors++;
        return;
      end
      exp = pending_words.pop_front();
      words_checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.element !== exp.element) begin
        $error("element: expected %0d, got %0d", exp.element, got.element);
        errors++;
      end
      if (got.element_valid !== exp.element_valid) begin
        $error("element_valid: expected %0b, got %0b", exp.element_valid, got.element_valid);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  list_shadow shadow = new();
  bit         send_quiet;

  ordered_list_insert_delete u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic req_t make_req(logic [1:0] m, int pos, logic [31:0] v);
    req_t r;
    r.mode     = m;
    r.position = pos[4:0];
    r.value    = v;
    return r;
  endfunction

  // Mix of corner values, a small pool for duplicates, and full-range words
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word, hold it until taken, then maybe idle a little
  task automatic send_request(req_t w);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    shadow.apply_request(w);
    if (!send_quiet && $urandom_range(99) < 21) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Result side: check accepted words, stall at random, one long hold-off, one stall-free stretch
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) shadow.check_word(rsp);
      if (!hold_done && shadow.words_checked == 80) begin
        hold_left = 250;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (shadow.words_checked >= 300 && shadow.words_checked < 380) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  // Stimulus
  initial begin
    int          n;
    int          r;
    int          pos;
    logic [31:0] v;
    send_quiet = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list cases, corner values, head/middle/tail, full list
    send_request(make_req(MODE_CLEAR, 0, '0));
    send_request(make_req(MODE_DUMP, 0, '0));
    send_request(make_req(MODE_DELETE, 0, 32'd5));
    send_request(make_req(MODE_INSERT, 31, 32'd9));
    send_request(make_req(MODE_INSERT, 0, 32'h8000_0000));
    send_request(make_req(MODE_INSERT, 1, 32'h7fff_ffff));
    send_request(make_req(MODE_INSERT, 1, 32'h0000_0000));
    send_request(make_req(MODE_INSERT, 0, 32'hffff_ffff));
    send_request(make_req(MODE_DUMP, 0, '0));
    send_request(make_req(MODE_DELETE, 0, 32'h0000_0000));
    while (shadow.fill < LIST_CAP)
      send_request(make_req(MODE_INSERT, $urandom_range(0, shadow.fill), $urandom));
    send_request(make_req(MODE_INSERT, 0, 32'd1));
    send_request(make_req(MODE_INSERT, 17, 32'd1));
    send_request(make_req(MODE_DUMP, 0, '0));
    send_request(make_req(MODE_CLEAR, 0, '0));
    send_request(make_req(MODE_DUMP, 0, '0));

    // Random: inserts outweigh deletes so the list often fills up
    for (n = 0; n < 200; n++) begin
      send_quiet = (n >= 100 && n < 160);
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(99) < 85) pos = $urandom_range(0, shadow.fill);
        else pos = $urandom_range(0, 31);
        send_request(make_req(MODE_INSERT, pos, pick_value()));
      end else if (r < 75) begin
        if (shadow.fill > 0 && $urandom_range(99) < 65)
          v = shadow.slots[$urandom_range(0, shadow.fill - 1)];
        else
          v = pick_value();
        send_request(make_req(MODE_DELETE, $urandom_range(0, 31), v));
      end else if (r < 80) begin
        send_request(make_req(MODE_CLEAR, $urandom_range(0, 31), $urandom));
      end else begin
        send_request(make_req(MODE_DUMP, $urandom_range(0, 31), $urandom));
      end
    end
    req_valid <= 1'b0;

    // Drain, then give a late stray word time to show up
    while (shadow.pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Ran %0d requests: %0d dumps, %0d full inserts, %0d bad positions, %0d misses.",
             shadow.requests, shadow.dumps, shadow.full_hits, shadow.bad_pos_hits,
             shadow.miss_hits);
    $display("Checked %0d result words against the shadow list.", shadow.words_checked);
    if (shadow.errors == 0 && shadow.pending_words.size() == 0) begin
      $display("PASS ordered_list_insert_delete");
    end else begin
      $display("FAIL ordered_list_insert_delete");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("FAIL ordered_list_insert_delete");
    $finish;
  end

endmodule

/* ordered_list_insert_delete.f */
+incdir+rtl/core
rtl/core/olid_pkg.sv
rtl/core/olid_rsp_reg.sv
rtl/core/ordered_list_insert_delete.sv
verif/tb_top.sv
